// ----- hdl/fnps_pkg.sv -----
// ----------------------------------------------------------------------------
// fnps_pkg
// Shared constants, register indexes and the lattice hash table for the
// fractal noise pixel shader.
// ----------------------------------------------------------------------------
package fnps_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_FREQUENCY = 3'd0;
  localparam logic [2:0] REG_OCTAVES   = 3'd1;
  localparam logic [2:0] REG_AMPLITUDE = 3'd2;
  localparam logic [2:0] REG_SEED      = 3'd3;

  localparam int unsigned FREQ_W = 25;
  localparam int unsigned AMP_W  = 17;
  localparam int unsigned NOISE_W = 24;  // one octave sample, 16 fraction bits
  localparam int unsigned QUOT_W  = 16;  // normalized noise, 16 fraction bits

  localparam logic [24:0] FREQUENCY_RST = 25'd167772;
  localparam logic [3:0]  OCTAVES_RST   = 4'd4;
  localparam logic [16:0] AMPLITUDE_RST = 17'd0;
  localparam logic [7:0]  SEED_RST      = 8'd0;

  typedef logic [7:0] byte_t;

  localparam byte_t HASH_TAB [256] = '{
    8'd208,8'd34,8'd231,8'd213,8'd32,8'd248,8'd233,8'd56,8'd161,8'd78,8'd24,8'd140,
    8'd71,8'd48,8'd140,8'd254,8'd245,8'd255,8'd247,8'd247,8'd40,8'd185,8'd248,8'd251,
    8'd245,8'd28,8'd124,8'd204,8'd204,8'd76,8'd36,8'd1,8'd107,8'd28,8'd234,8'd163,
    8'd202,8'd224,8'd245,8'd128,8'd167,8'd204,8'd9,8'd92,8'd217,8'd54,8'd239,8'd174,
    8'd173,8'd102,8'd193,8'd189,8'd190,8'd121,8'd100,8'd108,8'd167,8'd44,8'd43,8'd77,
    8'd180,8'd204,8'd8,8'd81,8'd70,8'd223,8'd11,8'd38,8'd24,8'd254,8'd210,8'd210,
    8'd177,8'd32,8'd81,8'd195,8'd243,8'd125,8'd8,8'd169,8'd112,8'd32,8'd97,8'd53,
    8'd195,8'd13,8'd203,8'd9,8'd47,8'd104,8'd125,8'd117,8'd114,8'd124,8'd165,8'd203,
    8'd181,8'd235,8'd193,8'd206,8'd70,8'd180,8'd174,8'd0,8'd167,8'd181,8'd41,8'd164,
    8'd30,8'd116,8'd127,8'd198,8'd245,8'd146,8'd87,8'd224,8'd149,8'd206,8'd57,8'd4,
    8'd192,8'd210,8'd65,8'd210,8'd129,8'd240,8'd178,8'd105,8'd228,8'd108,8'd245,8'd148,
    8'd140,8'd40,8'd35,8'd195,8'd38,8'd58,8'd65,8'd207,8'd215,8'd253,8'd65,8'd85,
    8'd208,8'd76,8'd62,8'd3,8'd237,8'd55,8'd89,8'd232,8'd50,8'd217,8'd64,8'd244,
    8'd157,8'd199,8'd121,8'd252,8'd90,8'd17,8'd212,8'd203,8'd149,8'd152,8'd140,8'd187,
    8'd234,8'd177,8'd73,8'd174,8'd193,8'd100,8'd192,8'd143,8'd97,8'd53,8'd145,8'd135,
    8'd19,8'd103,8'd13,8'd90,8'd135,8'd151,8'd199,8'd91,8'd239,8'd247,8'd33,8'd39,
    8'd145,8'd101,8'd120,8'd99,8'd3,8'd186,8'd86,8'd99,8'd41,8'd237,8'd203,8'd111,
    8'd79,8'd220,8'd135,8'd158,8'd42,8'd30,8'd154,8'd120,8'd67,8'd87,8'd167,8'd135,
    8'd176,8'd183,8'd191,8'd253,8'd115,8'd184,8'd21,8'd233,8'd58,8'd129,8'd233,8'd142,
    8'd39,8'd128,8'd211,8'd118,8'd137,8'd139,8'd255,8'd114,8'd20,8'd218,8'd113,8'd154,
    8'd27,8'd127,8'd246,8'd250,8'd1,8'd8,8'd198,8'd250,8'd209,8'd92,8'd222,8'd173,
    8'd21,8'd88,8'd102,8'd219
  };

  function automatic byte_t hash_lookup(input byte_t idx);
    return HASH_TAB[idx];
  endfunction

endpackage

// ----- hdl/fractal_noise_pixel_shade.sv -----
// ----------------------------------------------------------------------------
// fractal_noise_pixel_shade
// Darkens an RGBA pixel stream by fractal value noise of the pixel position.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock unless the output buffer is full, and
// returns one per clock while the receiver is ready. It chains a coordinate
// scaling register, MAX_OCTAVES octave cells of four stages each, a shift
// stage, 16 one-bit division cells for the normalization and an amplitude
// scaling register ahead of the darkening. All stages advance together; a
// two-entry output buffer absorbs downstream stalls; s_axis_tready drops only
// when it is full. Configuration must be written while no pixel is in flight.
module fractal_noise_pixel_shade import fnps_pkg::*; #(
  parameter int MAX_OCTAVES = 8,
  parameter int COORD_BITS  = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [24:0]         cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // x_coord, y_coord, red_in, green_in, blue_in, alpha_in (zero padded)
  input  logic [((2*COORD_BITS+39)/8)*8-1:0] s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // red_out, green_out, blue_out, alpha_out
  output logic [31:0]         m_axis_tdata
);

  localparam int DEPW = $clog2(MAX_OCTAVES + 1);
  localparam int AW   = NOISE_W + MAX_OCTAVES;
  localparam int CB   = COORD_BITS;

  // configuration registers
  logic [24:0] freq_q;
  logic [3:0]  oct_q;
  logic [16:0] amp_q;
  logic [7:0]  seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FREQUENCY_RST;
      oct_q  <= OCTAVES_RST;
      amp_q  <= AMPLITUDE_RST;
      seed_q <= SEED_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FREQUENCY: freq_q <= cfg_wdata_i;
        REG_OCTAVES:   oct_q  <= cfg_wdata_i[3:0];
        REG_AMPLITUDE: amp_q  <= cfg_wdata_i[16:0];
        REG_SEED:      seed_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // clamp the octave count
  logic [4:0]      depth_ext_w;
  logic [DEPW-1:0] depth_w;
  assign depth_ext_w = ({1'b0, oct_q} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : {1'b0, oct_q};
  assign depth_w     = depth_ext_w[DEPW-1:0];

  logic en_w;
  logic [1:0] cnt_q;
  assign en_w          = cnt_q != 2'd2;
  assign s_axis_tready = en_w;

  // scale coordinates into noise space
  logic [CB+24:0] prx_w, pry_w;
  logic [CB+56:0] prx_ext_w, pry_ext_w;
  assign prx_w     = s_axis_tdata[CB-1:0] * freq_q;
  assign pry_w     = s_axis_tdata[2*CB-1:CB] * freq_q;
  assign prx_ext_w = {32'd0, prx_w};
  assign pry_ext_w = {32'd0, pry_w};

  logic        v0_q;
  logic [31:0] px0_q, py0_q, rgba0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en_w) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      px0_q   <= prx_ext_w[31:0];
      py0_q   <= pry_ext_w[31:0];
      rgba0_q <= s_axis_tdata[2*CB+31:2*CB];
    end
  end

  // octave cell chain
  logic          oc_v    [MAX_OCTAVES+1];
  logic [31:0]   oc_px   [MAX_OCTAVES+1];
  logic [31:0]   oc_py   [MAX_OCTAVES+1];
  logic [AW-1:0] oc_acc  [MAX_OCTAVES+1];
  logic [31:0]   oc_rgba [MAX_OCTAVES+1];

  assign oc_v[0]    = v0_q;
  assign oc_px[0]   = px0_q;
  assign oc_py[0]   = py0_q;
  assign oc_acc[0]  = '0;
  assign oc_rgba[0] = rgba0_q;

  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    fnps_octave_cell #(
      .IDX(i), .MAXO(MAX_OCTAVES), .DEPW(DEPW), .AW(AW)
    ) u_cell (
      .clk_i, .rst_ni, .en_i(en_w), .depth_i(depth_w), .seed_i(seed_q),
      .valid_i(oc_v[i]), .px_i(oc_px[i]), .py_i(oc_py[i]),
      .acc_i(oc_acc[i]), .rgba_i(oc_rgba[i]),
      .valid_o(oc_v[i+1]), .px_o(oc_px[i+1]), .py_o(oc_py[i+1]),
      .acc_o(oc_acc[i+1]), .rgba_o(oc_rgba[i+1])
    );
  end

  // normalize: acc / (256 * (2^d - 1) * 2^(MAX-d))
  logic [AW-1:0]          dvd_w;
  logic [MAX_OCTAVES-1:0] dvs_w;
  assign dvd_w = (oc_acc[MAX_OCTAVES] >> 8) >> (DEPW'(MAX_OCTAVES) - depth_w);
  assign dvs_w = {MAX_OCTAVES{1'b1}} >> (DEPW'(MAX_OCTAVES) - depth_w);

  logic                   dv_v    [QUOT_W+1];
  logic [AW-1:0]          dv_rem  [QUOT_W+1];
  logic [MAX_OCTAVES-1:0] dv_dvs  [QUOT_W+1];
  logic [QUOT_W-1:0]      dv_quo  [QUOT_W+1];
  logic                   dv_zero [QUOT_W+1];
  logic [31:0]            dv_rgba [QUOT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v[0] <= 1'b0;
    end else if (en_w) begin
      dv_v[0] <= oc_v[MAX_OCTAVES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      dv_rem[0]  <= dvd_w;
      dv_dvs[0]  <= dvs_w;
      dv_quo[0]  <= '0;
      dv_zero[0] <= depth_w == '0;
      dv_rgba[0] <= oc_rgba[MAX_OCTAVES];
    end
  end

  for (genvar j = 0; j < QUOT_W; j++) begin : g_div
    fnps_div_cell #(.J(QUOT_W-1-j), .AW(AW), .DW(MAX_OCTAVES)) u_div (
      .clk_i, .rst_ni, .en_i(en_w),
      .valid_i(dv_v[j]), .rem_i(dv_rem[j]), .dvs_i(dv_dvs[j]),
      .quo_i(dv_quo[j]), .zero_i(dv_zero[j]), .rgba_i(dv_rgba[j]),
      .valid_o(dv_v[j+1]), .rem_o(dv_rem[j+1]), .dvs_o(dv_dvs[j+1]),
      .quo_o(dv_quo[j+1]), .zero_o(dv_zero[j+1]), .rgba_o(dv_rgba[j+1])
    );
  end

  // scale by amplitude
  logic        va_q;
  logic [16:0] nv_q;
  logic [31:0] rgba_a_q;
  logic [32:0] ampp_w;
  assign ampp_w = dv_quo[QUOT_W] * amp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_w) begin
      va_q <= dv_v[QUOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      nv_q     <= dv_zero[QUOT_W] ? 17'd0 : ampp_w[32:16];
      rgba_a_q <= dv_rgba[QUOT_W];
    end
  end

  // darken the color channels, floor at zero
  function automatic logic [7:0] darken(input logic [7:0] c, input logic [16:0] v);
    logic [25:0] p;
    logic [9:0]  d;
    p = (26'(c) * 26'(v)) + 26'd65535;
    d = p[25:16];
    return (d > {2'd0, c}) ? 8'd0 : 8'({2'd0, c} - d);
  endfunction

  logic [31:0] shaded_w;
  assign shaded_w = {rgba_a_q[31:24], darken(rgba_a_q[23:16], nv_q),
                     darken(rgba_a_q[15:8], nv_q), darken(rgba_a_q[7:0], nv_q)};

  // two-entry output buffer
  logic [31:0] buf_q [2];
  logic        wp_q, rp_q;
  logic        push_w, pop_w;
  assign push_w = va_q & en_w;
  assign pop_w  = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
    end else begin
      if (push_w) wp_q <= ~wp_q;
      if (pop_w)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_w) - 2'(pop_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_w) buf_q[wp_q] <= shaded_w;
  end

  assign m_axis_tvalid = cnt_q != 2'd0;
  assign m_axis_tdata  = buf_q[rp_q];

  // buffer occupancy stays within its two entries
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("output buffer overflow");

  // a stalled input side means results are waiting downstream
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output buffer");

  // a pop empties one entry unless a push refills it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_w && !push_w) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("output buffer count mismatch");

endmodule

// ----- hdl/fnps_octave_cell.sv -----
// ----------------------------------------------------------------------------
// fnps_octave_cell
// One octave of value noise: lattice hash, smoothstep weights, bilinear blend
// and weighted accumulation, in four pipeline stages.
// ----------------------------------------------------------------------------
module fnps_octave_cell import fnps_pkg::*; #(
  parameter int IDX  = 0,
  parameter int MAXO = 8,
  parameter int DEPW = 4,
  parameter int AW   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [DEPW-1:0] depth_i,
  input  logic [7:0]      seed_i,
  input  logic            valid_i,
  input  logic [31:0]     px_i,
  input  logic [31:0]     py_i,
  input  logic [AW-1:0]   acc_i,
  input  logic [31:0]     rgba_i,
  output logic            valid_o,
  output logic [31:0]     px_o,
  output logic [31:0]     py_o,
  output logic [AW-1:0]   acc_o,
  output logic [31:0]     rgba_o
);

  localparam int SHIFT = MAXO - 1 - IDX;

  logic [3:0]    vld_q;
  logic [31:0]   px_q [4];
  logic [31:0]   py_q [4];
  logic [AW-1:0] acc_q [4];
  logic [31:0]   rgba_q [4];
  logic [3:0]    act_q;

  // stage 1 payload
  logic [15:0] fx_q, fy_q;
  logic [31:0] ffx_q, ffy_q;
  logic [7:0]  xi_q, a0_q, a1_q;
  // stage 2 payload
  logic [16:0] wx_q, wy2_q;
  logic [7:0]  cs_q, ct_q, cu_q, cv_q;
  // stage 3 payload
  logic [24:0] lo_q, hi_q;
  logic [16:0] wy3_q;

  logic [7:0]  yi_w, xi1_w;
  logic [33:0] wxp_w, wyp_w;
  logic [41:0] blend_w;
  logic [AW-1:0] n_ext_w;

  assign yi_w  = py_i[31:24];
  assign xi1_w = xi_q + 8'd1;
  assign wxp_w = {2'd0, ffx_q[31:16]} * (18'd196608 - {1'b0, fx_q, 1'b0});
  assign wyp_w = {2'd0, ffy_q[31:16]} * (18'd196608 - {1'b0, fy_q, 1'b0});
  assign blend_w = (42'(17'd65536 - wy3_q) * 42'(lo_q)) + (42'(wy3_q) * 42'(hi_q));
  assign n_ext_w = AW'(blend_w[39:16]) << SHIFT;

  // advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  // carry coordinates, sum and color along the stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q[0]   <= px_i;      py_q[0]   <= py_i;
      acc_q[0]  <= acc_i;     rgba_q[0] <= rgba_i;
      act_q[0]  <= depth_i > DEPW'(IDX);
      for (int k = 1; k < 4; k++) begin
        px_q[k]   <= px_q[k-1];
        py_q[k]   <= py_q[k-1];
        rgba_q[k] <= rgba_q[k-1];
        act_q[k]  <= act_q[k-1];
        if (k < 3) acc_q[k] <= acc_q[k-1];
      end
      acc_q[3] <= act_q[2] ? acc_q[2] + n_ext_w : acc_q[2];
    end
  end

  // stage 1: fraction squares and row hashes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fx_q  <= px_i[23:8];
      fy_q  <= py_i[23:8];
      ffx_q <= px_i[23:8] * px_i[23:8];
      ffy_q <= py_i[23:8] * py_i[23:8];
      xi_q  <= px_i[31:24];
      a0_q  <= hash_lookup(yi_w + seed_i);
      a1_q  <= hash_lookup(yi_w + 8'd1 + seed_i);
    end
  end

  // stage 2: smoothstep weights and corner hashes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      wx_q  <= wxp_w[32:16];
      wy2_q <= wyp_w[32:16];
      cs_q  <= hash_lookup(a0_q + xi_q);
      ct_q  <= hash_lookup(a0_q + xi1_w);
      cu_q  <= hash_lookup(a1_q + xi_q);
      cv_q  <= hash_lookup(a1_q + xi1_w);
    end
  end

  // stage 3: blend along x
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lo_q  <= (25'(17'd65536 - wx_q) * 25'(cs_q)) + (25'(wx_q) * 25'(ct_q));
      hi_q  <= (25'(17'd65536 - wx_q) * 25'(cu_q)) + (25'(wx_q) * 25'(cv_q));
      wy3_q <= wy2_q;
    end
  end

  // hand on, coordinate doubled for the next octave
  assign valid_o = vld_q[3];
  assign px_o    = {px_q[3][30:0], 1'b0};
  assign py_o    = {py_q[3][30:0], 1'b0};
  assign acc_o   = acc_q[3];
  assign rgba_o  = rgba_q[3];

endmodule

// ----- hdl/fnps_div_cell.sv -----
// ----------------------------------------------------------------------------
// fnps_div_cell
// One restoring division step: resolves one quotient bit of the noise
// normalization and passes the remainder on.
// ----------------------------------------------------------------------------
module fnps_div_cell import fnps_pkg::*; #(
  parameter int J  = 0,
  parameter int AW = 32,
  parameter int DW = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [AW-1:0]     rem_i,
  input  logic [DW-1:0]     dvs_i,
  input  logic [QUOT_W-1:0] quo_i,
  input  logic              zero_i,
  input  logic [31:0]       rgba_i,
  output logic              valid_o,
  output logic [AW-1:0]     rem_o,
  output logic [DW-1:0]     dvs_o,
  output logic [QUOT_W-1:0] quo_o,
  output logic              zero_o,
  output logic [31:0]       rgba_o
);

  logic [AW-1:0] trial_w;
  logic          fits_w;

  assign trial_w = AW'(dvs_i) << J;
  assign fits_w  = rem_i >= trial_w;

  // hold the valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  // subtract the shifted divisor when it fits
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= fits_w ? rem_i - trial_w : rem_i;
      quo_o  <= quo_i | (QUOT_W'(fits_w) << J);
      dvs_o  <= dvs_i;
      zero_o <= zero_i;
      rgba_o <= rgba_i;
    end
  end

endmodule

// ----- bench/fnps_scoreboard.sv -----
// ----------------------------------------------------------------------------
// fnps_scoreboard
// Watches both pixel streams and the register port of the noise shader,
// predicts every shaded pixel and compares it with what the block returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnps_scoreboard import fnps_pkg::*; #(
  parameter int MAX_OCT = 8,
  parameter int CBITS   = 12,
  parameter int IN_W    = 56
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [2:0]      cfg_idx_i,
  input  logic [24:0]     cfg_wdata_i,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [IN_W-1:0] in_data_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic [31:0]     out_data_i,
  output int              errors_o,
  output int              pending_o
);

  logic [24:0] freq_q;
  logic [3:0]  oct_q;
  logic [16:0] amp_q;
  logic [7:0]  seed_q;
  logic [31:0] shaded_q[$];

  assign pending_o = shaded_q.size();

  function automatic logic [63:0] corner(logic [7:0] col, logic [7:0] row);
    logic [7:0] a;
    a = HASH_TAB[8'(row + seed_q)];
    return 64'(HASH_TAB[8'(a + col)]);
  endfunction

  function automatic logic [63:0] ease(logic [63:0] f);
    logic [63:0] t;
    t = (f * f) >> 16;
    return (t * (64'd196608 - 2 * f)) >> 16;
  endfunction

  function automatic logic [63:0] dim(logic [63:0] c, logic [63:0] v);
    logic [63:0] d;
    d = (c * v + 64'd65535) >> 16;
    return (d > c) ? 64'd0 : c - d;
  endfunction

  // Fractal noise sum, normalization and darkening of one pixel
  function automatic logic [31:0] shade(logic [IN_W-1:0] pix);
    logic [63:0] px, py, cx, cy, wx, wy, lo, hi, n, acc, wsum, v, w;
    logic [7:0]  xi, yi;
    int depth;
    px = 64'(pix[CBITS-1:0]) * 64'(freq_q);
    py = 64'(pix[2*CBITS-1:CBITS]) * 64'(freq_q);
    depth = (oct_q > MAX_OCT) ? MAX_OCT : int'(oct_q);
    acc = 0; wsum = 0; v = 0;
    for (int i = 0; i < depth; i++) begin
      w  = 64'd1 << (MAX_OCT - 1 - i);
      cx = (px << i) >> 8;
      cy = (py << i) >> 8;
      xi = cx[23:16];
      yi = cy[23:16];
      wx = ease(64'(cx[15:0]));
      wy = ease(64'(cy[15:0]));
      lo = (65536 - wx) * corner(xi, yi) + wx * corner(8'(xi + 1), yi);
      hi = (65536 - wx) * corner(xi, 8'(yi + 1)) + wx * corner(8'(xi + 1), 8'(yi + 1));
      n  = ((65536 - wy) * lo + wy * hi) >> 16;
      acc  += n * w;
      wsum += w;
    end
    if (wsum != 0) v = ((acc / (wsum << 8)) * 64'(amp_q)) >> 16;
    return {pix[2*CBITS+31 -: 8],
            8'(dim(64'(pix[2*CBITS+23 -: 8]), v)),
            8'(dim(64'(pix[2*CBITS+15 -: 8]), v)),
            8'(dim(64'(pix[2*CBITS+7 -: 8]), v))};
  endfunction

  // Track registers, queue predictions, compare returned pixels
  always @(posedge clk_i or negedge rst_ni) begin
    logic [31:0] exp_pix;
    int bad;
    bad = 0;
    if (!rst_ni) begin
      freq_q <= FREQUENCY_RST;
      oct_q  <= OCTAVES_RST;
      amp_q  <= AMPLITUDE_RST;
      seed_q <= SEED_RST;
      errors_o <= 0;
      shaded_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) shaded_q.push_back(shade(in_data_i));
      if (out_valid_i && out_ready_i) begin
        if (shaded_q.size() == 0) begin
          $display("%0t: unexpected pixel expected none actual %h", $time, out_data_i);
          bad++;
        end else begin
          exp_pix = shaded_q.pop_front();
          for (int k = 0; k < 4; k++)
            if (exp_pix[8*k +: 8] !== out_data_i[8*k +: 8]) begin
              $display("%0t: channel %0d expected %0d actual %0d", $time, k,
                       exp_pix[8*k +: 8], out_data_i[8*k +: 8]);
              bad++;
            end
        end
      end
      if (bad != 0) errors_o <= errors_o + bad;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FREQUENCY: freq_q <= cfg_wdata_i;
          REG_OCTAVES:   oct_q  <= cfg_wdata_i[3:0];
          REG_AMPLITUDE: amp_q  <= cfg_wdata_i[16:0];
          REG_SEED:      seed_q <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- bench/fractal_noise_pixel_shade_test.sv -----
// ----------------------------------------------------------------------------
// fractal_noise_pixel_shade_test
// Drives pixels and register settings into the noise shader under random
// stalls on both streams; the scoreboard checks every returned pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fractal_noise_pixel_shade_test;
  import fnps_pkg::*;

  localparam int CBITS = 12;
  localparam int IN_W  = ((2*CBITS+39)/8)*8;
  localparam int PIPE_DEPTH = 4*8 + 20;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_idx_i = '0;
  logic [24:0]     cfg_wdata_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;
  int              errors, pending, cycles;
  bit              calm_q = 1'b0;   // no idling in the closing stretch
  bit              hold_q = 1'b0;   // long receiver hold-off

  always #4 clk_i = ~clk_i;

  fractal_noise_pixel_shade DUT (.*);

  fnps_scoreboard #(.MAX_OCT(8), .CBITS(CBITS), .IN_W(IN_W)) u_board (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i(s_axis_tvalid), .in_ready_i(s_axis_tready), .in_data_i(s_axis_tdata),
    .out_valid_i(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending));

  // Abort on a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (hold_q) m_axis_tready <= 1'b0;
      else if (!calm_q && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 6);
        m_axis_tready <= 1'b0;
        repeat (burst) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else m_axis_tready <= 1'b1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [24:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
  endtask

  // Offer one pixel, possibly after an idle burst, and wait for acceptance
  task automatic send_pixel(logic [11:0] x, logic [11:0] y, logic [31:0] rgba);
    if (!calm_q && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({rgba, y, x});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_random(int count);
    repeat (count) send_pixel(12'($urandom), 12'($urandom), $urandom);
    s_axis_tvalid <= 1'b0;
  endtask

  initial begin
    logic [24:0] freq_set[5] = '{25'd0, 25'd167772, 25'd1048576, 25'd16777216, 25'h1FFFFFF};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes at reset settings, then full darkening
    send_pixel(12'd0, 12'd0, 32'hFFFFFFFF);
    send_pixel(12'hFFF, 12'hFFF, 32'h00000000);
    s_axis_tvalid <= 1'b0;
    drain();
    write_reg(REG_AMPLITUDE, 25'd65536);
    write_reg(REG_FREQUENCY, 25'd16777216);
    send_pixel(12'hFFF, 12'd0, 32'h80FF7F01);
    send_pixel(12'h555, 12'hAAA, 32'hFFFFFFFF);
    s_axis_tvalid <= 1'b0;
    drain();
    // Zero octaves passes through; octaves above the limit saturate
    write_reg(REG_OCTAVES, 25'd0);
    send_random(4);
    drain();
    write_reg(REG_OCTAVES, 25'd15);
    write_reg(REG_AMPLITUDE, 25'h1FFFF);
    write_reg(REG_SEED, 25'd255);
    write_reg(3'd7, 25'h1FFFFFF);   // unmapped index, ignored
    send_random(6);
    drain();

    // Random phases over register settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_FREQUENCY, (ph < 5) ? freq_set[ph] : 25'($urandom));
      write_reg(REG_OCTAVES, (ph == 2) ? 25'd8 : 25'($urandom_range(0, 15)));
      write_reg(REG_AMPLITUDE, (ph == 3) ? 25'd0 : 25'($urandom_range(0, 131071)));
      write_reg(REG_SEED, 25'($urandom_range(0, 255)));
      if (ph == 4) begin
        hold_q = 1'b1;
        fork
          begin repeat (300) @(posedge clk_i); hold_q = 1'b0; end
          send_random(100);
        join
      end else send_random(90);
      drain();
    end

    // Closing stretch without idling
    calm_q = 1'b1;
    send_random(60);
    drain();

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
